/* rtl/core/mms_pkg.sv */
// ----------------------------------------------------------------------------
// Motion magnitude smoother package
// Shared constants, widths and the sequencer state type.
// ----------------------------------------------------------------------------
package mms_pkg;

    // Window of magnitudes that are averaged
    localparam int WINDOW = 50;

    // Field widths
    localparam int ACCEL_W = 12;
    localparam int MAG_W   = 17;
    localparam int SUM_W   = 23;
    localparam int SQ_W    = 26;
    localparam int RAD_W   = 34;
    localparam int REM_W   = 18;

    // Window bookkeeping widths
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Division remainder width; the remainder stays below the count
    localparam int DREM_W = SUM_W - MAG_W;

    // Iteration counts
    localparam int AXES      = 3;
    localparam int ROOT_STEP = MAG_W;
    localparam int DIV_STEP  = MAG_W;
    localparam int STEP_W    = 5;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/mms_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mms_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 50
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/motion_magnitude_smoother.sv */
// ----------------------------------------------------------------------------
// Motion magnitude smoother
// Differential vector magnitude of accelerometer samples and its moving mean.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one sample per transfer: tdata holds accel_x,
// accel_y and accel_z (12 bits each, from bit 0 up) and tuser holds
// start_of_record, which clears the previous sample and the window.
// The master stream returns one result per sample: tdata holds magnitude
// (bits 16:0) and magnitude_average (bits 33:17), both with 4 fraction bits.
// After the input transfer the sequencer squares the three axis differences
// on one multiplier, runs 17 root steps and 17 divide steps on one shared
// compare-subtract unit, updates the window and then loads the output, which
// raises o_m_tvalid. The block takes no new sample until it has loaded the
// result and gone back to idle.
// The result sits in an output register; while it waits, the next sample is
// accepted and worked on, and the sequencer waits in its last state only if
// the earlier result is still not taken.
// Reset clears the previous sample, window pointer, count, sum and the
// output valid. The magnitude store itself is not cleared.
// ----------------------------------------------------------------------------
module motion_magnitude_smoother (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // accel_x[11:0], accel_y[23:12], accel_z[35:24], zero pad
    input  logic        i_s_tuser,   // start_of_record
    // Master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // magnitude[16:0], magnitude_average[33:17], zero pad
);

    localparam int AW = mms_pkg::ACCEL_W;

    mms_pkg::t_state r_state, n_state;

    // Sample and history registers
    logic [AW-1:0] r_x, r_y, r_z;
    logic [AW-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic          r_have_prev;
    logic          r_use_prev;
    logic [mms_pkg::PTR_W-1:0] r_ptr;
    logic [mms_pkg::CNT_W-1:0] r_count;
    logic [mms_pkg::SUM_W-1:0] r_sum;

    // Iteration registers
    logic [mms_pkg::STEP_W-1:0] r_step;
    logic [mms_pkg::RAD_W-1:0]  r_rad;
    logic [mms_pkg::REM_W-1:0]  r_rem;
    logic [mms_pkg::MAG_W-1:0]  r_root;
    logic [mms_pkg::MAG_W-1:0]  r_mag;

    // Output register
    logic                      r_out_valid;
    logic [mms_pkg::MAG_W-1:0] r_out_mag;
    logic [mms_pkg::MAG_W-1:0] r_out_avg;

    // Control decodes
    logic in_xfer;
    logic out_xfer;
    logic last_step;
    logic ram_we;
    logic load_out;

    // Datapath signals
    logic [AW-1:0]             cur_s, cur_p;
    logic [AW:0]               diff_s;
    logic [AW-1:0]             abs_d;
    logic [2*AW-1:0]           prod;
    logic [19:0]               op_a, op_b;
    logic [20:0]               sub;
    logic                      ge;
    logic [19:0]               root_cur;
    logic [6:0]                div_cur;
    logic [mms_pkg::MAG_W-1:0] old_mag;
    logic                      full;
    logic [mms_pkg::SUM_W-1:0] n_sum;
    logic [mms_pkg::CNT_W-1:0] n_count;
    logic [mms_pkg::PTR_W-1:0] n_ptr;

    assign in_xfer   = i_s_tvalid && o_s_tready;
    assign out_xfer  = r_out_valid && i_m_tready;
    assign last_step = (r_state == mms_pkg::ST_SQUARE)
                     ? (r_step == mms_pkg::STEP_W'(mms_pkg::AXES - 1))
                     : (r_step == mms_pkg::STEP_W'(mms_pkg::ROOT_STEP - 1));

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mms_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = mms_pkg::ST_SQUARE;
            end
            mms_pkg::ST_SQUARE: begin
                if (last_step) n_state = mms_pkg::ST_ROOT;
            end
            mms_pkg::ST_ROOT: begin
                if (last_step) n_state = mms_pkg::ST_UPDATE;
            end
            mms_pkg::ST_UPDATE: begin
                n_state = mms_pkg::ST_DIVIDE;
            end
            mms_pkg::ST_DIVIDE: begin
                if (last_step) n_state = mms_pkg::ST_DONE;
            end
            mms_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) n_state = mms_pkg::ST_IDLE;
            end
            default: n_state = mms_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            mms_pkg::ST_IDLE:   o_s_tready = 1'b1;
            mms_pkg::ST_UPDATE: ram_we     = 1'b1;
            mms_pkg::ST_DONE:   load_out   = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    // Squaring of one axis difference per cycle on a single multiplier
    always_comb begin
        case (r_step[1:0])
            2'd0:    begin cur_s = r_x; cur_p = r_prev_x; end
            2'd1:    begin cur_s = r_y; cur_p = r_prev_y; end
            default: begin cur_s = r_z; cur_p = r_prev_z; end
        endcase
        diff_s = {cur_s[AW-1], cur_s} - {cur_p[AW-1], cur_p};
        abs_d  = diff_s[AW] ? AW'(-diff_s) : diff_s[AW-1:0];
        prod   = abs_d * abs_d;
    end

    // Shared compare-subtract unit for root and divide steps
    assign root_cur = {r_rem, r_rad[mms_pkg::RAD_W-1 -: 2]};
    assign div_cur  = {r_rem[mms_pkg::DREM_W-1:0], r_root[mms_pkg::MAG_W-1]};

    always_comb begin
        if (r_state == mms_pkg::ST_DIVIDE) begin
            op_a = 20'(div_cur);
            op_b = 20'(r_count);
        end else begin
            op_a = root_cur;
            op_b = {1'b0, r_root, 2'b01};
        end
        sub = {1'b0, op_a} - {1'b0, op_b};
        ge  = !sub[20];
    end

    // Window update values
    always_comb begin
        full    = (r_count == mms_pkg::CNT_W'(mms_pkg::WINDOW));
        n_sum   = r_sum - (full ? mms_pkg::SUM_W'(old_mag) : '0)
                + mms_pkg::SUM_W'(r_root);
        n_count = full ? r_count : r_count + 1'b1;
        n_ptr   = (r_ptr == mms_pkg::PTR_W'(mms_pkg::WINDOW - 1)) ? '0 : r_ptr + 1'b1;
    end

    // Magnitude history store
    mms_ram #(
        .WIDTH (mms_pkg::MAG_W),
        .DEPTH (mms_pkg::WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (r_root),
        .i_raddr (r_ptr),
        .o_rdata (old_mag)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mms_pkg::ST_IDLE;
            r_have_prev <= 1'b0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
        end else begin
            r_state <= n_state;

            // Step counter restarts on every state change
            if (n_state != r_state) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 1'b1;
            end

            // A new record clears the history
            if (in_xfer && i_s_tuser) begin
                r_have_prev <= 1'b0;
                r_ptr       <= '0;
                r_count     <= '0;
                r_sum       <= '0;
            end

            if (r_state == mms_pkg::ST_UPDATE) begin
                r_prev_x    <= r_x;
                r_prev_y    <= r_y;
                r_prev_z    <= r_z;
                r_have_prev <= 1'b1;
                r_ptr       <= n_ptr;
                r_count     <= n_count;
                r_sum       <= n_sum;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x        <= i_s_tdata[AW-1:0];
            r_y        <= i_s_tdata[2*AW-1:AW];
            r_z        <= i_s_tdata[3*AW-1:2*AW];
            r_use_prev <= r_have_prev && !i_s_tuser;
            r_rad      <= '0;
        end

        unique case (r_state)
            mms_pkg::ST_SQUARE: begin
                // Sum of squares lands above eight zero bits of root scaling
                if (r_use_prev) begin
                    r_rad <= r_rad + mms_pkg::RAD_W'({prod, 8'd0});
                end
                r_rem  <= '0;
                r_root <= '0;
            end
            mms_pkg::ST_ROOT: begin
                // One root bit per cycle
                r_rad  <= {r_rad[mms_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= ge ? sub[mms_pkg::REM_W-1:0] : root_cur[mms_pkg::REM_W-1:0];
                r_root <= {r_root[mms_pkg::MAG_W-2:0], ge};
            end
            mms_pkg::ST_UPDATE: begin
                // Set up the division of the new sum by the new count
                r_mag  <= r_root;
                r_rem  <= mms_pkg::REM_W'(n_sum[mms_pkg::SUM_W-1 -: mms_pkg::DREM_W]);
                r_root <= n_sum[mms_pkg::MAG_W-1:0];
            end
            mms_pkg::ST_DIVIDE: begin
                // One quotient bit per cycle
                r_rem  <= ge ? mms_pkg::REM_W'(sub[mms_pkg::DREM_W-1:0])
                             : mms_pkg::REM_W'(div_cur[mms_pkg::DREM_W-1:0]);
                r_root <= {r_root[mms_pkg::MAG_W-2:0], ge};
            end
            default: ;
        endcase

        if (load_out) begin
            r_out_mag <= r_mag;
            r_out_avg <= r_root;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_avg, r_out_mag};

    // The pointer always stays inside the window
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < mms_pkg::PTR_W'(mms_pkg::WINDOW))
        else $error("window pointer out of range");

    // The divisor is a valid, nonzero count during division
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mms_pkg::ST_DIVIDE) |->
            (r_count != '0 && r_count <= mms_pkg::CNT_W'(mms_pkg::WINDOW)))
        else $error("divisor count out of range");

    // The partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mms_pkg::ST_DIVIDE) |-> (r_rem < mms_pkg::REM_W'(r_count)))
        else $error("division remainder not below divisor");

    // An input transfer is never followed by a result load in the next cycle
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !load_out)
        else $error("result loaded too early");

endmodule

/* test/motion_magnitude_smoother_tb.sv */
// ----------------------------------------------------------------------------
// Motion magnitude smoother testbench
// Streams accelerometer samples into the block and checks every result
// against a cycle-free predictor of the magnitude and of its moving mean.
// Directed samples cover missing history, record starts and the largest
// differences. Random records then walk, jump and sit on the rails, mostly long
// enough to fill and wrap the averaging window. Both streams idle in random
// bursts, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module motion_magnitude_smoother_tb;

    localparam int RANDOM_SAMPLES = 500;
    localparam int QUIET_TAIL     = 60;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 150;
    localparam int DRAIN_CYCLES   = 100;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct {
        logic signed [mms_pkg::ACCEL_W-1:0] x;
        logic signed [mms_pkg::ACCEL_W-1:0] y;
        logic signed [mms_pkg::ACCEL_W-1:0] z;
        logic                               start;
    } t_sample;

    typedef struct {
        logic [mms_pkg::MAG_W-1:0] mag;
        logic [mms_pkg::MAG_W-1:0] avg;
    } t_smoothed;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mms_pkg::IN_DATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [39:0]                   m_tdata;

    // Stimulus and expectations
    t_sample   sample_queue[$];
    t_smoothed expected_results[$];
    t_sample   s_item;
    int        send_idle;
    int        take_hold;
    bit        long_hold_done;
    logic [31:0] cycle_cnt = '0;

    // Predictor state
    logic signed [mms_pkg::ACCEL_W-1:0] last_x, last_y, last_z;
    bit                                 have_last;
    logic [mms_pkg::MAG_W-1:0]          win_store[mms_pkg::WINDOW];
    int                                 win_ptr;
    int                                 win_cnt;
    logic [mms_pkg::SUM_W-1:0]          win_sum = '0;

    // Run statistics
    int errors;
    int samples_sent;
    int results_checked;
    int records_seen;
    int full_window_hits;
    int input_stall_cycles;

    motion_magnitude_smoother u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Floor of the square root, built up one result bit at a time.
    function automatic logic [mms_pkg::MAG_W-1:0] int_sqrt(input longint unsigned v);
        logic [mms_pkg::MAG_W:0] root;
        logic [mms_pkg::MAG_W:0] trial;
        root = '0;
        for (int b = mms_pkg::MAG_W; b >= 0; b--) begin
            trial    = root;
            trial[b] = 1'b1;
            if (longint'(trial) * longint'(trial) <= v) begin
                root = trial;
            end
        end
        return root[mms_pkg::MAG_W-1:0];
    endfunction

    // Advance the predictor by one sample and queue the result it implies.
    function automatic void predict_sample(input t_sample s);
        int                        dx, dy, dz;
        longint unsigned           sq_sum;
        logic [mms_pkg::MAG_W-1:0] mag;
        t_smoothed                 res;
        if (s.start) begin
            have_last = 1'b0;
            win_ptr   = 0;
            win_cnt   = 0;
            win_sum   = '0;
            records_seen++;
        end
        mag = '0;
        if (have_last) begin
            dx     = int'(s.x) - int'(last_x);
            dy     = int'(s.y) - int'(last_y);
            dz     = int'(s.z) - int'(last_z);
            sq_sum = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
            mag    = int_sqrt(sq_sum << 8);
        end
        last_x    = s.x;
        last_y    = s.y;
        last_z    = s.z;
        have_last = 1'b1;

        // Once the window is full the oldest magnitude leaves the sum.
        if (win_cnt == mms_pkg::WINDOW) begin
            win_sum = win_sum - win_store[win_ptr];
            full_window_hits++;
        end else begin
            win_cnt++;
        end
        win_store[win_ptr] = mag;
        win_sum            = win_sum + mag;
        win_ptr            = (win_ptr == mms_pkg::WINDOW - 1) ? 0 : win_ptr + 1;

        res.mag = mag;
        res.avg = mms_pkg::MAG_W'(win_sum / win_cnt);
        expected_results.push_back(res);
    endfunction

    // Idling density changes with bits 10:9 of the cycle counter; the tail of the run is calm.
    function automatic bit burst_due();
        if (sample_queue.size() < QUIET_TAIL) begin
            return 1'b0;
        end
        case (cycle_cnt[10:9])
            2'd0:    return 1'b0;
            2'd1:    return $urandom_range(0, 3) == 0;
            2'd2:    return $urandom_range(0, 1) == 0;
            default: return $urandom_range(0, 7) != 0;
        endcase
    endfunction

    function automatic void add_sample(input int x, input int y, input int z, input bit start);
        t_sample s;
        s.x     = x[mms_pkg::ACCEL_W-1:0];
        s.y     = y[mms_pkg::ACCEL_W-1:0];
        s.z     = z[mms_pkg::ACCEL_W-1:0];
        s.start = start;
        sample_queue.push_back(s);
    endfunction

    function automatic int pick_rail();
        case ($urandom_range(0, 4))
            0:       return -2048;
            1:       return 2047;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic int walk_axis(input int v);
        int n;
        n = v + $urandom_range(0, 64) - 32;
        if (n > 2047) n = 2047;
        if (n < -2048) n = -2048;
        return n;
    endfunction

    // Sender: offers the next sample whenever the slot is free and no idle
    // burst is running; a transfer feeds the predictor.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_sample(s_item);
                samples_sent++;
            end
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_tvalid <= 1'b0;
                end else if (sample_queue.size() != 0 && burst_due()) begin
                    send_idle = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    s_item   = sample_queue.pop_front();
                    s_tdata  <= {{(mms_pkg::IN_DATA_W - 3 * mms_pkg::ACCEL_W){1'b0}},
                                 s_item.z, s_item.y, s_item.x};
                    s_tuser  <= s_item.start;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stall bursts plus one long hold that fills the
    // block and pushes back on its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (take_hold > 0) begin
            take_hold--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            take_hold      = LONG_HOLD - 1;
            m_tready       <= 1'b0;
        end else if (burst_due()) begin
            take_hold = $urandom_range(0, 7);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each output transfer against the oldest expectation.
    always @(posedge clk) begin : result_check
        t_smoothed want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, magnitude %0d average %0d", $time,
                         m_tdata[mms_pkg::MAG_W-1:0],
                         m_tdata[2*mms_pkg::MAG_W-1:mms_pkg::MAG_W]);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[mms_pkg::MAG_W-1:0] !== want.mag) begin
                    errors++;
                    $display("%0t: magnitude mismatch, expected %0d, actual %0d", $time,
                             want.mag, m_tdata[mms_pkg::MAG_W-1:0]);
                end
                if (m_tdata[2*mms_pkg::MAG_W-1:mms_pkg::MAG_W] !== want.avg) begin
                    errors++;
                    $display("%0t: average mismatch, expected %0d, actual %0d", $time,
                             want.avg, m_tdata[2*mms_pkg::MAG_W-1:mms_pkg::MAG_W]);
                end
            end
            results_checked++;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int produced;
        int rec_len;
        int style;
        int x, y, z;

        // No history yet after reset: the first sample counts as a start.
        add_sample(100, -200, 300, 1'b0);
        add_sample(2047, 2047, 2047, 1'b0);
        add_sample(-2048, -2048, -2048, 1'b0);     // largest difference on all axes
        add_sample(2047, -2048, 2047, 1'b0);
        add_sample(-2048, 2047, -2048, 1'b0);
        add_sample(0, 0, 0, 1'b1);                 // record start clears the window
        add_sample(0, 0, 0, 1'b0);                 // no change
        add_sample(1, 0, 0, 1'b0);
        add_sample(1, 1, 0, 1'b0);
        add_sample(1, 1, 1, 1'b0);
        add_sample(-1, -1, -1, 1'b0);
        add_sample(-2048, 0, 2047, 1'b0);
        add_sample(2047, 0, -2048, 1'b0);
        add_sample(2047, 2047, 2047, 1'b1);        // start on the rails
        add_sample(-2048, -2048, -2048, 1'b1);     // back-to-back starts
        add_sample(2047, 2047, 2047, 1'b0);
        add_sample(-1, 0, 1, 1'b0);
        add_sample(1365, -1366, 682, 1'b0);
        add_sample(-683, 1023, -1024, 1'b0);
        add_sample(0, -2048, 0, 1'b0);

        // Random records: mostly long enough to fill and wrap the window.
        produced = 0;
        while (produced < RANDOM_SAMPLES) begin
            rec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : $urandom_range(20, 140);
            style   = $urandom_range(0, 3);
            x       = int'($urandom_range(0, 4095)) - 2048;
            y       = int'($urandom_range(0, 4095)) - 2048;
            z       = int'($urandom_range(0, 4095)) - 2048;
            for (int i = 0; i < rec_len && produced < RANDOM_SAMPLES; i++) begin
                case (style)
                    0: begin
                        x = int'($urandom_range(0, 4095)) - 2048;
                        y = int'($urandom_range(0, 4095)) - 2048;
                        z = int'($urandom_range(0, 4095)) - 2048;
                    end
                    1: begin
                        x = pick_rail();
                        y = pick_rail();
                        z = pick_rail();
                    end
                    default: begin
                        x = walk_axis(x);
                        y = walk_axis(y);
                        z = walk_axis(z);
                    end
                endcase
                // A few records run on without a start flag.
                add_sample(x, y, z, (i == 0) && ($urandom_range(0, 9) != 0));
                produced++;
            end
        end

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (sample_queue.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples in %0d records; %0d of them with a full window.",
                 samples_sent, records_seen, full_window_hits);
        $display("Checked %0d results; the input waited on the block for %0d cycles.",
                 results_checked, input_stall_cycles);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Timeout with %0d results still expected", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mms_pkg.sv
rtl/core/mms_ram.sv
rtl/core/motion_magnitude_smoother.sv
test/motion_magnitude_smoother_tb.sv
